// ===== sv/ihw_pkg.sv =====
`default_nettype none

package ihw_pkg;

    // Storage depth of the record buffer and the widest record it can hold.
    localparam int BUF_DEPTH = 16;
    localparam int BUF_AW = $clog2(BUF_DEPTH);
    localparam int RECORD_BYTES_DEF = 16;

    // Command codes of the input word.
    localparam logic [1:0] CMD_DATA = 2'd0;
    localparam logic [1:0] CMD_SEEK = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    // Fixed characters of the hex text.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // Byte positions of a record ahead of the data bytes.
    localparam logic [4:0] SEQ_COUNT = 5'd0;
    localparam logic [4:0] SEQ_ADDR_HI = 5'd1;
    localparam logic [4:0] SEQ_ADDR_LO = 5'd2;
    localparam logic [4:0] SEQ_TYPE = 5'd3;
    localparam logic [4:0] SEQ_DATA = 5'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [15:0] load_address;
    } ihw_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } ihw_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLON,
        ST_HI,
        ST_LO,
        ST_NL
    } ihw_state_t;

    // What follows once the record in flight is done.
    typedef enum logic [1:0] {
        POST_NONE,
        POST_SEEK,
        POST_END
    } ihw_post_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;
        logic seek_now;
        logic start_rec;
        logic rec_end;
        logic emit_colon;
        logic emit_hi;
        logic emit_lo;
        logic emit_nl;
        logic last;
        logic finish_rec;
        logic load_addr;
    } ihw_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic will_fill;
        logic at_csum;
        logic out_free;
    } ihw_sts_t;

    // Uppercase ASCII hex digit of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ihw_ctrl.sv =====
`default_nettype none

module ihw_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    cmd,
    input  wire ihw_pkg::ihw_sts_t sts,
    output ihw_pkg::ihw_ctl_t  ctl
);

    ihw_pkg::ihw_state_t state_reg, state_next;
    ihw_pkg::ihw_post_t  post_reg, post_next;

    // State and pending follow-up registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ihw_pkg::ST_IDLE;
            post_reg <= ihw_pkg::POST_NONE;
        end else begin
            state_reg <= state_next;
            post_reg <= post_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        post_next = post_reg;
        case (state_reg)
            ihw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (cmd)
                        ihw_pkg::CMD_DATA: begin
                            if (sts.will_fill) begin
                                state_next = ihw_pkg::ST_COLON;
                                post_next = ihw_pkg::POST_NONE;
                            end
                        end
                        ihw_pkg::CMD_SEEK: begin
                            if (!sts.count_zero) begin
                                state_next = ihw_pkg::ST_COLON;
                                post_next = ihw_pkg::POST_SEEK;
                            end
                        end
                        ihw_pkg::CMD_CLOSE: begin
                            state_next = ihw_pkg::ST_COLON;
                            post_next = sts.count_zero ? ihw_pkg::POST_NONE
                                                       : ihw_pkg::POST_END;
                        end
                        default: begin
                            state_next = ihw_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ihw_pkg::ST_COLON: begin
                if (sts.out_free) begin
                    state_next = ihw_pkg::ST_HI;
                end
            end
            ihw_pkg::ST_HI: begin
                if (sts.out_free) begin
                    state_next = ihw_pkg::ST_LO;
                end
            end
            ihw_pkg::ST_LO: begin
                if (sts.out_free) begin
                    state_next = sts.at_csum ? ihw_pkg::ST_NL : ihw_pkg::ST_HI;
                end
            end
            ihw_pkg::ST_NL: begin
                if (sts.out_free) begin
                    state_next = (post_reg == ihw_pkg::POST_END) ? ihw_pkg::ST_COLON
                                                                 : ihw_pkg::ST_IDLE;
                    post_next = ihw_pkg::POST_NONE;
                end
            end
            default: begin
                state_next = ihw_pkg::ST_IDLE;
                post_next = ihw_pkg::POST_NONE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        ctl = '0;
        s_ready = 1'b0;
        case (state_reg)
            ihw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.take_in = 1'b1;
                    case (cmd)
                        ihw_pkg::CMD_DATA: begin
                            ctl.start_rec = sts.will_fill;
                        end
                        ihw_pkg::CMD_SEEK: begin
                            ctl.seek_now = sts.count_zero;
                            ctl.start_rec = !sts.count_zero;
                        end
                        ihw_pkg::CMD_CLOSE: begin
                            ctl.start_rec = 1'b1;
                            ctl.rec_end = sts.count_zero;
                        end
                        default: begin
                            ctl.take_in = 1'b1;
                        end
                    endcase
                end
            end
            ihw_pkg::ST_COLON: begin
                ctl.emit_colon = sts.out_free;
            end
            ihw_pkg::ST_HI: begin
                ctl.emit_hi = sts.out_free;
            end
            ihw_pkg::ST_LO: begin
                ctl.emit_lo = sts.out_free;
            end
            ihw_pkg::ST_NL: begin
                if (sts.out_free) begin
                    ctl.emit_nl = 1'b1;
                    ctl.finish_rec = 1'b1;
                    ctl.last = (post_reg != ihw_pkg::POST_END);
                    ctl.load_addr = (post_reg == ihw_pkg::POST_SEEK);
                    // A close that flushed a record goes on to the end record.
                    ctl.start_rec = (post_reg == ihw_pkg::POST_END);
                    ctl.rec_end = (post_reg == ihw_pkg::POST_END);
                end
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ihw_dpath.sv =====
`default_nettype none

module ihw_dpath #(
    parameter int RECORD_BYTES = ihw_pkg::RECORD_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ihw_pkg::ihw_in_t  s_data,
    input  wire ihw_pkg::ihw_ctl_t ctl,
    output ihw_pkg::ihw_sts_t      sts,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ihw_pkg::ihw_out_t      m_data
);

    localparam logic [4:0] FILL_LEVEL = 5'(RECORD_BYTES);

    logic [7:0]  buf_mem [ihw_pkg::BUF_DEPTH];
    logic [4:0]  count_reg, count_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] pend_reg;
    logic [7:0]  csum_reg, csum_next;
    logic [4:0]  seq_reg, seq_next;
    logic        type_reg;
    logic        m_valid_reg, m_valid_next;
    ihw_pkg::ihw_out_t m_data_reg, m_data_next;
    logic [7:0]  rd_byte_reg;

    logic [4:0]  count_inc;
    logic [4:0]  rd_idx;
    logic [7:0]  cur_byte;

    assign count_inc = count_reg + 5'd1;
    // The buffer read is registered and addressed by the byte position about to be current.
    assign rd_idx = seq_next - ihw_pkg::SEQ_DATA;

    // Status toward the controller.
    always_comb begin
        sts.count_zero = (count_reg == 5'd0);
        sts.will_fill = (count_inc >= FILL_LEVEL);
        sts.at_csum = ({1'b0, seq_reg} == ({1'b0, count_reg} + 6'd4));
        sts.out_free = !m_valid_reg || m_ready;
    end

    // Byte of the record at the current position.
    always_comb begin
        case (seq_reg)
            ihw_pkg::SEQ_COUNT:   cur_byte = {3'd0, count_reg};
            ihw_pkg::SEQ_ADDR_HI: cur_byte = addr_reg[15:8];
            ihw_pkg::SEQ_ADDR_LO: cur_byte = addr_reg[7:0];
            ihw_pkg::SEQ_TYPE:    cur_byte = {7'd0, type_reg};
            default: begin
                if (sts.at_csum) begin
                    cur_byte = 8'd0 - csum_reg;
                end else begin
                    cur_byte = rd_byte_reg;
                end
            end
        endcase
    end

    // Record buffer writes and registered reads.
    always_ff @(posedge aclk) begin
        if (ctl.take_in && (s_data.cmd == ihw_pkg::CMD_DATA)) begin
            buf_mem[count_reg[ihw_pkg::BUF_AW-1:0]] <= s_data.data_byte;
        end
        rd_byte_reg <= buf_mem[rd_idx[ihw_pkg::BUF_AW-1:0]];
    end

    // Count, address, checksum and byte position.
    always_comb begin
        count_next = count_reg;
        addr_next = addr_reg;
        csum_next = csum_reg;
        seq_next = seq_reg;
        if (ctl.take_in && (s_data.cmd == ihw_pkg::CMD_DATA)) begin
            count_next = count_inc;
        end
        if (ctl.seek_now) begin
            addr_next = s_data.load_address;
        end
        if (ctl.emit_lo) begin
            csum_next = csum_reg + cur_byte;
            seq_next = seq_reg + 5'd1;
        end
        if (ctl.finish_rec) begin
            addr_next = ctl.load_addr ? pend_reg : addr_reg + {11'd0, count_reg};
            count_next = 5'd0;
            csum_next = 8'd0;
        end
        if (ctl.start_rec) begin
            csum_next = 8'd0;
            seq_next = ihw_pkg::SEQ_COUNT;
        end
    end

    // Output word register.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next = m_data_reg;
        if (ctl.emit_colon) begin
            m_valid_next = 1'b1;
            m_data_next.out_char = ihw_pkg::CHAR_COLON;
            m_data_next.last_char = 1'b0;
        end else if (ctl.emit_hi) begin
            m_valid_next = 1'b1;
            m_data_next.out_char = ihw_pkg::hex_char(cur_byte[7:4]);
            m_data_next.last_char = 1'b0;
        end else if (ctl.emit_lo) begin
            m_valid_next = 1'b1;
            m_data_next.out_char = ihw_pkg::hex_char(cur_byte[3:0] & ihw_pkg::NIBBLE_MASK);
            m_data_next.last_char = 1'b0;
        end else if (ctl.emit_nl) begin
            m_valid_next = 1'b1;
            m_data_next.out_char = ihw_pkg::CHAR_LF;
            m_data_next.last_char = ctl.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 5'd0;
            addr_reg <= 16'd0;
            csum_reg <= 8'd0;
            seq_reg <= ihw_pkg::SEQ_COUNT;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            addr_reg <= addr_next;
            csum_reg <= csum_next;
            seq_reg <= seq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (ctl.take_in) begin
            pend_reg <= s_data.load_address;
        end
        if (ctl.start_rec) begin
            type_reg <= ctl.rec_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/intel_hex_record_writer.sv =====
`default_nettype none

// Channel | Direction | Word type          | Handshake
// s_      | in        | ihw_pkg::ihw_in_t  | s_valid / s_ready
// m_      | out       | ihw_pkg::ihw_out_t | m_valid / m_ready
//
// An append that leaves the record open is simply stored. A record with n data
// bytes is sent as 2n+12 characters, one per cycle from the character sequencer
// while the output is free; a close that flushes an open record adds 12 more.
// The input is held off while a record is being sent; the last character of
// an item may still wait in the output register while the next item enters.
// Reset (aresetn low, synchronous) empties the record and clears the address.
module intel_hex_record_writer #(
    parameter int RECORD_BYTES = ihw_pkg::RECORD_BYTES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ihw_pkg::ihw_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ihw_pkg::ihw_out_t     m_data
);

    ihw_pkg::ihw_ctl_t ctl;
    ihw_pkg::ihw_sts_t sts;

    // Character sequencer.
    ihw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (s_data.cmd),
        .sts     (sts),
        .ctl     (ctl)
    );

    // Record buffer, address, checksum and output word.
    ihw_dpath #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctl     (ctl),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
